@@ sv/assert_macros.svh @@
// assertion helpers used by the mapper rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define TPNB_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tpnb check failed");

// condition in one cycle implies result in the next
`define TPNB_CHECK_NEXT(lbl, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("tpnb check failed");

`endif

@@ sv/tpnb_pkg.sv @@
// ----------------------------------------------------------------------------
// tpnb_pkg
// shared constants and types of the touch pad note and bend mapper
// ----------------------------------------------------------------------------
package tpnb_pkg;

    localparam int FRAC      = 16;
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_Q_W   = 26;

    typedef logic [DIV_NUM_W-1:0] div_num_t;
    typedef logic [DIV_DEN_W-1:0] div_den_t;
    typedef logic [DIV_Q_W-1:0]   div_quo_t;

    localparam logic [2:0] REG_COLUMNS  = 3'd0;
    localparam logic [2:0] REG_ROWS     = 3'd1;
    localparam logic [2:0] REG_BASE     = 3'd2;
    localparam logic [2:0] REG_INTERVAL = 3'd3;
    localparam logic [2:0] REG_BEND     = 3'd4;
    localparam logic [2:0] REG_ZONE     = 3'd5;
    localparam logic [2:0] REG_RANGE    = 3'd6;

    localparam logic [6:0]  ZONE_MAX  = 7'd95;
    localparam logic [16:0] MIN_RANGE = 17'd655;

endpackage

@@ sv/tpnb_div.sv @@
// ----------------------------------------------------------------------------
// tpnb_div
// pipelined restoring divider, one quotient bit per stage, global stall
// ----------------------------------------------------------------------------
module tpnb_div (
    input  logic               clk,
    input  logic               en,
    input  tpnb_pkg::div_num_t num,
    input  tpnb_pkg::div_den_t den,
    output tpnb_pkg::div_quo_t quo
);

    localparam int QW = tpnb_pkg::DIV_Q_W;
    localparam int NW = tpnb_pkg::DIV_NUM_W;
    localparam int WC = tpnb_pkg::DIV_DEN_W + tpnb_pkg::DIV_Q_W;

    tpnb_pkg::div_num_t rem_reg [QW];
    tpnb_pkg::div_quo_t q_reg   [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        tpnb_pkg::div_num_t rem_in;
        tpnb_pkg::div_quo_t q_in;
        tpnb_pkg::div_num_t rem_next;
        tpnb_pkg::div_quo_t q_next;
        logic [WC-1:0]      trial;
        logic [WC-1:0]      wide_rem;

        if (j == 0)
        begin : g_first
            assign rem_in = num;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        always_comb
        begin
            trial    = WC'(den) << (QW - 1 - j);
            wide_rem = WC'(rem_in);
            q_next   = q_in;
            rem_next = rem_in;
            if (wide_rem >= trial)
            begin
                rem_next          = NW'(wide_rem - trial);
                q_next[QW-1-j]    = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

@@ sv/touch_pad_note_bend_mapper.sv @@
// ----------------------------------------------------------------------------
// touch_pad_note_bend_mapper
// pipeline: 6 arithmetic stages plus one stage per quotient bit of the 26 bit
// pipelined dividers, from request accept to result valid
// throughput: one request per cycle; a two-entry output buffer stalls the
// whole pipeline only when both entries hold results
// reset: asynchronous active low, registers return to defaults, pipeline empty
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_pad_note_bend_mapper #(
    parameter int MAX_COLUMNS = 16,
    parameter int MAX_ROWS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [17:0] touch_x,
    input  logic signed [17:0] touch_y,
    input  logic signed [17:0] anchor_x,
    input  logic signed [17:0] start_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               on_grid,
    output logic [7:0]         pad_number,
    output logic [8:0]         note_number,
    output logic [15:0]        pad_centre,
    output logic signed [15:0] bend_amount,
    output logic signed [23:0] expression_level
);

    localparam int DQ  = tpnb_pkg::DIV_Q_W;
    localparam int NST = 6 + DQ;

    typedef struct packed {
        logic       on;
        logic [7:0] pad;
        logic [8:0] note;
        logic       bneg;
        logic       eneg;
    } side_t;

    typedef struct packed {
        logic               on;
        logic [7:0]         pad;
        logic [8:0]         note;
        logic [15:0]        centre;
        logic signed [15:0] bend;
        logic signed [23:0] expr;
    } out_t;

    // configuration registers
    logic [4:0]  grid_columns_reg;
    logic [4:0]  grid_rows_reg;
    logic [6:0]  base_note_reg;
    logic [4:0]  row_interval_reg;
    logic [13:0] bend_per_pad_reg;
    logic [6:0]  in_tune_percent_reg;
    logic [16:0] drag_range_reg;

    logic        wr_en;
    logic [2:0]  wr_index;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign wr_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg    <= 5'd8;
            grid_rows_reg       <= 5'd4;
            base_note_reg       <= 7'd36;
            row_interval_reg    <= 5'd5;
            bend_per_pad_reg    <= 14'd256;
            in_tune_percent_reg <= 7'd0;
            drag_range_reg      <= 17'd32768;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tpnb_pkg::REG_COLUMNS:  grid_columns_reg    <= pwdata[4:0];
                tpnb_pkg::REG_ROWS:     grid_rows_reg       <= pwdata[4:0];
                tpnb_pkg::REG_BASE:     base_note_reg       <= pwdata[6:0];
                tpnb_pkg::REG_INTERVAL: row_interval_reg    <= pwdata[4:0];
                tpnb_pkg::REG_BEND:     bend_per_pad_reg    <= pwdata[13:0];
                tpnb_pkg::REG_ZONE:     in_tune_percent_reg <= pwdata[6:0];
                tpnb_pkg::REG_RANGE:    drag_range_reg      <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_index)
            tpnb_pkg::REG_COLUMNS:  prdata = 32'(grid_columns_reg);
            tpnb_pkg::REG_ROWS:     prdata = 32'(grid_rows_reg);
            tpnb_pkg::REG_BASE:     prdata = 32'(base_note_reg);
            tpnb_pkg::REG_INTERVAL: prdata = 32'(row_interval_reg);
            tpnb_pkg::REG_BEND:     prdata = 32'(bend_per_pad_reg);
            tpnb_pkg::REG_ZONE:     prdata = 32'(in_tune_percent_reg);
            tpnb_pkg::REG_RANGE:    prdata = 32'(drag_range_reg);
            default:                prdata = 32'd0;
        endcase
    end

    // derived configuration; the user must keep it stable while requests are in flight, the block does not enforce it
    logic [4:0]  cols;
    logic [4:0]  rows;
    logic [6:0]  pct;
    logic [7:0]  zone_den;
    logic [16:0] range;

    always_comb
    begin
        cols     = (int'(grid_columns_reg) > MAX_COLUMNS) ? 5'(MAX_COLUMNS) : grid_columns_reg;
        rows     = (int'(grid_rows_reg) > MAX_ROWS) ? 5'(MAX_ROWS) : grid_rows_reg;
        pct      = (in_tune_percent_reg > tpnb_pkg::ZONE_MAX) ? tpnb_pkg::ZONE_MAX
                                                             : in_tune_percent_reg;
        zone_den = 8'd200 - {pct, 1'b0};
        range    = (drag_range_reg < tpnb_pkg::MIN_RANGE) ? tpnb_pkg::MIN_RANGE
                                                          : drag_range_reg;
    end

    // pipeline control
    logic               en;
    logic [NST-1:0]     valid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    out_t               out_reg;
    out_t               skid_reg;
    out_t               fin;
    logic               push;
    logic               pop;

    assign en       = !skid_valid_reg;
    assign in_ready = en;
    assign push     = en && valid_reg[NST-1];
    assign pop      = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NST-2:0], in_valid};
        end
    end

    // stage 0: input capture
    logic signed [17:0] tx0_reg;
    logic signed [17:0] ty0_reg;
    logic signed [17:0] ax0_reg;
    logic signed [17:0] sy0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx0_reg <= touch_x;
            ty0_reg <= touch_y;
            ax0_reg <= anchor_x;
            sy0_reg <= start_y;
        end
    end

    // stage 1: scale by grid size, floor into column and row, bend and expression differences
    logic signed [23:0] colp;
    logic signed [23:0] rowp;
    logic signed [18:0] dx;
    logic signed [7:0]  col1_next;
    logic signed [7:0]  row1_next;
    logic signed [24:0] d1_next;
    logic signed [18:0] ed1_next;
    logic signed [7:0]  col1_reg;
    logic signed [7:0]  row1_reg;
    logic signed [24:0] d1_reg;
    logic signed [18:0] ed1_reg;

    always_comb
    begin
        colp      = 24'(tx0_reg) * 24'($signed({1'b0, cols}));
        rowp      = 24'(ty0_reg) * 24'($signed({1'b0, rows}));
        col1_next = colp[23:16];
        row1_next = rowp[23:16];
        dx        = $signed({tx0_reg[17], tx0_reg}) - $signed({ax0_reg[17], ax0_reg});
        d1_next   = 25'(dx) * 25'($signed({1'b0, cols}));
        ed1_next  = $signed({sy0_reg[17], sy0_reg}) - $signed({ty0_reg[17], ty0_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col1_reg <= col1_next;
            row1_reg <= row1_next;
            d1_reg   <= d1_next;
            ed1_reg  <= ed1_next;
        end
    end

    // stage 2: grid decode, bend split into whole pads and remainder, divider numerators
    side_t              side_reg [NST-1:2];
    side_t              side2_next;
    logic               on2;
    logic [11:0]        padw;
    logic [4:0]         rowup;
    logic [10:0]        notew;
    logic [24:0]        dmag;
    logic [24:0]        msum;
    logic [24:0]        rw;
    logic [18:0]        eabs;
    logic [7:0]         n2_next;
    logic signed [16:0] r2_next;
    tpnb_pkg::div_num_t cnum2_next;
    tpnb_pkg::div_num_t enum2_next;
    logic [7:0]         n2_reg;
    logic signed [16:0] r2_reg;
    tpnb_pkg::div_num_t cnum_reg [2:5];
    tpnb_pkg::div_num_t enum_reg [2:5];

    always_comb
    begin
        on2   = !col1_reg[7] && (col1_reg[6:0] < {2'b00, cols})
             && !row1_reg[7] && (row1_reg[6:0] < {2'b00, rows});
        padw  = 12'(row1_reg[6:0]) * 12'(cols) + 12'(col1_reg[6:0]);
        rowup = rows - row1_reg[4:0] - 5'd1;
        notew = 11'(base_note_reg) + 11'(col1_reg[4:0]) + 11'(rowup) * 11'(row_interval_reg);
        side2_next.on   = on2;
        side2_next.pad  = on2 ? padw[7:0] : 8'd0;
        side2_next.note = !on2 ? 9'd0 : ((notew > 11'd511) ? 9'd511 : notew[8:0]);
        side2_next.bneg = d1_reg[24];
        side2_next.eneg = ed1_reg[18];
        dmag    = d1_reg[24] ? 25'(-d1_reg) : 25'(d1_reg);
        msum    = dmag + 25'd32768;
        n2_next = msum[23:16];
        rw      = dmag - {1'b0, n2_next, 16'd0};
        r2_next = $signed(rw[16:0]);
        cnum2_next = tpnb_pkg::DIV_NUM_W'({col1_reg[4:0], 1'b1, 16'd0})
                   + tpnb_pkg::DIV_NUM_W'(cols);
        eabs       = ed1_reg[18] ? 19'(-ed1_reg) : 19'(ed1_reg);
        enum2_next = tpnb_pkg::DIV_NUM_W'({eabs[17:0], 16'd0})
                   + tpnb_pkg::DIV_NUM_W'(range >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[2] <= side2_next;
            n2_reg      <= n2_next;
            r2_reg      <= r2_next;
            cnum_reg[2] <= cnum2_next;
            enum_reg[2] <= enum2_next;
        end
    end

    for (genvar k = 3; k < NST; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar k = 3; k < 6; k++)
    begin : g_num
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cnum_reg[k] <= cnum_reg[k-1];
                enum_reg[k] <= enum_reg[k-1];
            end
        end
    end

    // stage 3: staircase with in-tune zones, steps scaled by 2^16 * den
    logic [16:0]        ar;
    logic               ramp_on;
    logic signed [26:0] r200;
    logic signed [26:0] pctq;
    logic signed [26:0] ramp;
    logic [31:0]        whole;
    logic signed [32:0] stepsw;
    logic [30:0]        steps3_next;
    logic [30:0]        steps3_reg;

    always_comb
    begin
        ar      = r2_reg[16] ? 17'(-r2_reg) : 17'(r2_reg);
        ramp_on = (25'(ar) * 25'd200) > {2'b00, pct, 16'd0};
        r200    = 27'(r2_reg) * 27'sd200;
        pctq    = $signed({4'b0000, pct, 16'd0});
        if (!ramp_on)
            ramp = '0;
        else if (!r2_reg[16] && (r2_reg != 17'sd0))
            ramp = r200 - pctq;
        else
            ramp = r200 + pctq;
        whole       = (32'(n2_reg) * 32'(zone_den)) << 16;
        stepsw      = $signed({1'b0, whole}) + 33'(ramp);
        steps3_next = stepsw[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            steps3_reg <= steps3_next;
        end
    end

    // stage 4: times bend per pad
    logic [44:0] x4_next;
    logic [44:0] x4_reg;

    assign x4_next = 45'(steps3_reg) * 45'(bend_per_pad_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x4_reg <= x4_next;
        end
    end

    // stage 5: rounding offset and the 2^16 part of the divisor
    logic [45:0]        ysum;
    tpnb_pkg::div_num_t y5_next;
    tpnb_pkg::div_num_t y5_reg;

    always_comb
    begin
        ysum    = 46'(x4_reg) + 46'({zone_den, 15'd0});
        y5_next = tpnb_pkg::DIV_NUM_W'(ysum[45:16]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y5_reg <= y5_next;
        end
    end

    // stages 6 and on: dividers
    tpnb_pkg::div_quo_t bquo;
    tpnb_pkg::div_quo_t cquo;
    tpnb_pkg::div_quo_t equo;

    tpnb_div u_bend_div (
        .clk (clk),
        .en  (en),
        .num (y5_reg),
        .den (tpnb_pkg::DIV_DEN_W'(zone_den)),
        .quo (bquo)
    );

    tpnb_div u_centre_div (
        .clk (clk),
        .en  (en),
        .num (cnum_reg[5]),
        .den (tpnb_pkg::DIV_DEN_W'({cols, 1'b0})),
        .quo (cquo)
    );

    tpnb_div u_expr_div (
        .clk (clk),
        .en  (en),
        .num (enum_reg[5]),
        .den (range),
        .quo (equo)
    );

    // final sign and saturation
    logic signed [27:0] eq;
    logic signed [27:0] es;

    always_comb
    begin
        fin.on     = side_reg[NST-1].on;
        fin.pad    = side_reg[NST-1].pad;
        fin.note   = side_reg[NST-1].note;
        fin.centre = side_reg[NST-1].on ? cquo[15:0] : 16'd0;
        if (!side_reg[NST-1].bneg)
            fin.bend = (bquo > 26'd32767) ? 16'sh7fff : $signed(bquo[15:0]);
        else
            fin.bend = (bquo > 26'd32768) ? 16'sh8000 : $signed(16'(26'd0 - bquo));
        eq = $signed({2'b00, equo});
        es = 28'sd32768 + (side_reg[NST-1].eneg ? -eq : eq);
        if (es > 28'sd8388607)
            fin.expr = 24'sh7fffff;
        else if (es < -28'sd8388608)
            fin.expr = 24'sh800000;
        else
            fin.expr = es[23:0];
    end

    // output register and skid buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= fin;
            end
            else
            begin
                out_reg <= fin;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign on_grid          = out_reg.on;
    assign pad_number       = out_reg.pad;
    assign note_number      = out_reg.note;
    assign pad_centre       = out_reg.centre;
    assign bend_amount      = out_reg.bend;
    assign expression_level = out_reg.expr;

    `TPNB_CHECK(a_skid_blocks_input, skid_valid_reg |-> (out_valid_reg && !in_ready))
    `TPNB_CHECK(a_off_grid_zero, (out_valid_reg && !on_grid) |-> (pad_number == 8'd0 && note_number == 9'd0 && pad_centre == 16'd0))
    `TPNB_CHECK_NEXT(a_accept_enters, in_valid && in_ready, valid_reg[0])

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the touch pad note and bend mapper: programs the
// register port, streams touch requests with random gaps and output stalls,
// and compares every result against a local predictor of the mapping
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic              on_grid;
        logic [7:0]        pad_number;
        logic [8:0]        note_number;
        logic [15:0]       pad_centre;
        logic signed [15:0] bend_amount;
        logic signed [23:0] expression_level;
    } mapping_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    class mapping_scoreboard;
        int  cols_reg = 8;
        int  rows_reg = 4;
        int  base_reg = 36;
        int  interval_reg = 5;
        int  bend_reg = 256;
        int  zone_reg = 0;
        int  range_reg = 32768;
        mapping_t pending[$];
        int  checked = 0;

        function void set_reg(int idx, int val);
            case (idx)
                tpnb_pkg::REG_COLUMNS:  cols_reg = val & 'h1f;
                tpnb_pkg::REG_ROWS:     rows_reg = val & 'h1f;
                tpnb_pkg::REG_BASE:     base_reg = val & 'h7f;
                tpnb_pkg::REG_INTERVAL: interval_reg = val & 'h1f;
                tpnb_pkg::REG_BEND:     bend_reg = val & 'h3fff;
                tpnb_pkg::REG_ZONE:     zone_reg = val & 'h7f;
                tpnb_pkg::REG_RANGE:    range_reg = val & 'h1ffff;
                default: ;
            endcase
        endfunction

        function longint floor_q(longint v);
            if (v >= 0)
                return v >>> tpnb_pkg::FRAC;
            return -(((-v) + (64'sd1 <<< tpnb_pkg::FRAC) - 1) >>> tpnb_pkg::FRAC);
        endfunction

        function longint round_div(longint num, longint den);
            if (num >= 0)
                return (num + den / 2) / den;
            return -(((-num) + den / 2) / den);
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_request(logic signed [17:0] tx_i, logic signed [17:0] ty_i,
                                   logic signed [17:0] ax_i, logic signed [17:0] sy_i);
            longint one, tx, ty, ax, sy, cols, rows, col, row, nt, d, m, pct, n, r, ar;
            longint den, ramp, steps, mag, bend, range, expr;
            mapping_t res;
            one = 64'sd1 <<< tpnb_pkg::FRAC;
            tx = tx_i; ty = ty_i; ax = ax_i; sy = sy_i;
            cols = cols_reg > 16 ? 16 : cols_reg;
            rows = rows_reg > 16 ? 16 : rows_reg;
            col = floor_q(tx * cols);
            row = floor_q(ty * rows);
            res = '0;
            res.on_grid = col >= 0 && col < cols && row >= 0 && row < rows;
            if (res.on_grid)
            begin
                nt = base_reg + col + (rows - 1 - row) * interval_reg;
                res.pad_number = row * cols + col;
                res.note_number = clip(nt, 0, 511);
                res.pad_centre = ((2 * col + 1) * one + cols) / (2 * cols);
            end
            d = (tx - ax) * cols;
            m = d < 0 ? -d : d;
            pct = zone_reg > 95 ? 95 : zone_reg;
            n = (m + one / 2) >>> tpnb_pkg::FRAC;
            r = m - n * one;
            ar = r < 0 ? -r : r;
            den = 2 * (100 - pct);
            ramp = 0;
            if (ar * 200 > pct * one)
                ramp = r > 0 ? 200 * r - pct * one : 200 * r + pct * one;
            steps = n * one * den + ramp;
            mag = round_div(steps * bend_reg, den * one);
            bend = clip(d < 0 ? -mag : mag, -32768, 32767);
            range = range_reg < one / 100 ? one / 100 : range_reg;
            expr = clip(one / 2 + round_div((sy - ty) * one, range), -8388608, 8388607);
            res.bend_amount = bend;
            res.expression_level = expr;
            pending.push_back(res);
        endfunction

        task check_result(mapping_t got);
            mapping_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.on_grid !== want.on_grid)
                report_mismatch("on_grid", got.on_grid, want.on_grid);
            if (got.pad_number !== want.pad_number)
                report_mismatch("pad_number", got.pad_number, want.pad_number);
            if (got.note_number !== want.note_number)
                report_mismatch("note_number", got.note_number, want.note_number);
            if (got.pad_centre !== want.pad_centre)
                report_mismatch("pad_centre", got.pad_centre, want.pad_centre);
            if (got.bend_amount !== want.bend_amount)
                report_mismatch("bend_amount", got.bend_amount, want.bend_amount);
            if (got.expression_level !== want.expression_level)
                report_mismatch("expression_level", got.expression_level,
                                want.expression_level);
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [17:0] touch_x = '0;
    logic signed [17:0] touch_y = '0;
    logic signed [17:0] anchor_x = '0;
    logic signed [17:0] start_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               on_grid;
    logic [7:0]         pad_number;
    logic [8:0]         note_number;
    logic [15:0]        pad_centre;
    logic signed [15:0] bend_amount;
    logic signed [23:0] expression_level;

    mapping_scoreboard board = new();
    bit quiet_phase = 1'b0;
    bit hold_sink = 1'b0;
    int sent = 0;

    always #4 clk = ~clk;

    touch_pad_note_bend_mapper u_top (.*);

    // result side
    initial
    begin
        int gap;
        @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 6);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({on_grid, pad_number, note_number, pad_centre,
                                bend_amount, expression_level});
    end

    task automatic write_reg(input logic [2:0] idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic drain_pipeline();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_touch(input logic signed [17:0] tx, input logic signed [17:0] ty,
                              input logic signed [17:0] ax, input logic signed [17:0] sy);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        touch_x  <= tx;
        touch_y  <= ty;
        anchor_x <= ax;
        start_y  <= sy;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_request(tx, ty, ax, sy);
        sent++;
    endtask

    function automatic logic signed [17:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 18'sh1ffff;
            2: return -18'sh20000;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic random_touches(input int count);
        logic signed [17:0] tx;
        logic signed [17:0] ty;
        for (int i = 0; i < count; i++)
        begin
            tx = pick_coord();
            ty = pick_coord();
            send_touch(tx, ty, ($urandom_range(0, 1) ? tx + $urandom_range(0, 20000) - 10000
                       : pick_coord()), pick_coord());
        end
        in_valid <= 1'b0;
    endtask

    task automatic random_config();
        write_reg(tpnb_pkg::REG_COLUMNS,  $urandom_range(0, 31));
        write_reg(tpnb_pkg::REG_ROWS,     $urandom_range(0, 31));
        write_reg(tpnb_pkg::REG_BASE,     $urandom_range(0, 127));
        write_reg(tpnb_pkg::REG_INTERVAL, $urandom_range(0, 31));
        write_reg(tpnb_pkg::REG_BEND,     $urandom_range(0, 16383));
        write_reg(tpnb_pkg::REG_ZONE,     $urandom_range(0, 127));
        write_reg(tpnb_pkg::REG_RANGE,    $urandom_range(0, 131071));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at reset settings
        send_touch(18'sd0, 18'sd0, 18'sd0, 18'sd0);
        send_touch(18'sh1ffff, 18'sh1ffff, -18'sh20000, -18'sh20000);
        send_touch(-18'sh20000, -18'sh20000, 18'sh1ffff, 18'sh1ffff);
        send_touch(18'sd65535, 18'sd65535, 18'sd0, 18'sd0);
        send_touch(18'sd65536, 18'sd32768, 18'sd8192, 18'sd40000);
        send_touch(-18'sd1, 18'sd100, 18'sd4096, 18'sd100);
        in_valid <= 1'b0;
        drain_pipeline();

        // extremes: max grid, wide zone, high notes, small range
        write_reg(tpnb_pkg::REG_COLUMNS, 31);
        write_reg(tpnb_pkg::REG_ROWS, 16);
        write_reg(tpnb_pkg::REG_BASE, 127);
        write_reg(tpnb_pkg::REG_INTERVAL, 31);
        write_reg(tpnb_pkg::REG_BEND, 16383);
        write_reg(tpnb_pkg::REG_ZONE, 127);
        write_reg(tpnb_pkg::REG_RANGE, 1);
        send_touch(18'sd65535, 18'sd0, 18'sd0, 18'sh1ffff);
        send_touch(18'sd2048, 18'sd2000, 18'sd4096, -18'sh20000);
        send_touch(18'sd30000, 18'sd60000, 18'sd0, 18'sd0);
        send_touch(18'sd100, 18'sd100, 18'sh1ffff, 18'sd0);
        in_valid <= 1'b0;
        drain_pipeline();

        // zero grid, zero bend, max range
        write_reg(tpnb_pkg::REG_COLUMNS, 0);
        write_reg(tpnb_pkg::REG_ROWS, 0);
        write_reg(tpnb_pkg::REG_BEND, 0);
        write_reg(tpnb_pkg::REG_ZONE, 50);
        write_reg(tpnb_pkg::REG_RANGE, 131071);
        send_touch(18'sd1000, 18'sd1000, 18'sd0, 18'sd5000);
        send_touch(18'sd40000, 18'sd20000, -18'sd40000, 18'sd0);
        in_valid <= 1'b0;
        drain_pipeline();

        // single pad, minimal settings
        write_reg(tpnb_pkg::REG_COLUMNS, 1);
        write_reg(tpnb_pkg::REG_ROWS, 1);
        write_reg(tpnb_pkg::REG_BASE, 0);
        write_reg(tpnb_pkg::REG_INTERVAL, 0);
        write_reg(tpnb_pkg::REG_BEND, 3);
        write_reg(tpnb_pkg::REG_ZONE, 0);
        write_reg(tpnb_pkg::REG_RANGE, 655);
        send_touch(18'sd32768, 18'sd32768, 18'sd0, 18'sd0);
        send_touch(18'sd98304, 18'sd1, 18'sd0, 18'sd655);
        in_valid <= 1'b0;
        drain_pipeline();

        // random phases with random settings
        for (int p = 0; p < 4; p++)
        begin
            random_config();
            random_touches(120);
            drain_pipeline();
        end

        // output stalled long while input keeps offering
        write_reg(tpnb_pkg::REG_COLUMNS, 8);
        write_reg(tpnb_pkg::REG_ZONE, 20);
        hold_sink = 1'b1;
        fork
            random_touches(60);
            begin
                repeat (200) @(posedge clk);
                hold_sink = 1'b0;
            end
        join
        drain_pipeline();

        // steady stream, no idling
        quiet_phase = 1'b1;
        random_config();
        random_touches(100);
        drain_pipeline();

        $display("covered %0d touch requests, %0d results over several register settings",
                 sent, board.checked);
        $display("including grid, zone, range extremes and long output back-pressure");
        if (error_count == 0 && board.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
